### src/assert_macros.svh
// Assertion helpers for the contrast stretch block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)

`endif

`endif

### src/pcs_pkg.sv
package pcs_pkg;

    localparam int PIX_W      = 8;
    localparam int PROD_W     = 2 * PIX_W;
    localparam int DIVD_W     = PROD_W + 1;
    localparam int DIVS_W     = PIX_W + 1;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = PIX_W / DIV_STEPS;

    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

    localparam int APB_DW = 32;
    localparam int APB_AW = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_IN_LOW   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IN_HIGH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_OUT_LOW  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUT_HIGH = 2'd3;

    // rounded division in flight: remainder, doubled divisor, quotient so far
    typedef struct packed {
        logic [DIVD_W-1:0] rem;
        logic [DIVS_W-1:0] dvs;
        logic [PIX_W-1:0]  quo;
    } pcs_div_t;

endpackage

### src/pcs_div_stage.sv
`include "assert_macros.svh"

module pcs_div_stage #(
    parameter int STAGE = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    input  pcs_pkg::pcs_div_t up_data,
    output logic             up_ready,
    output logic             dn_valid,
    output pcs_pkg::pcs_div_t dn_data,
    input  logic             dn_ready
);
    import pcs_pkg::*;

    localparam int HI_BIT = PIX_W - 1 - DIV_STEPS * STAGE;
    localparam int LO_BIT = HI_BIT - DIV_STEPS + 1;

    logic     valid_reg;
    pcs_div_t data_reg;
    pcs_div_t data_next;
    logic     adv;

    assign up_ready = !valid_reg || dn_ready;
    assign adv      = up_valid && up_ready;

    // restoring steps, one quotient bit each
    always_comb
    begin
        logic [DIVD_W-1:0] sh;
        data_next = up_data;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            sh = DIVD_W'(up_data.dvs) << (HI_BIT - j);
            if (data_next.rem >= sh)
            begin
                data_next.rem = data_next.rem - sh;
                data_next.quo = data_next.quo | (PIX_W'(1) << (HI_BIT - j));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    `ASSERT_PROP(a_rem_bound, clk, rst_n,
        valid_reg |-> (data_reg.rem < (DIVD_W'(data_reg.dvs) << LO_BIT)),
        "divider remainder out of range")
    `ASSERT_NEVER(a_zero_divisor, clk, rst_n,
        valid_reg && (data_reg.dvs == '0),
        "divider stage holds zero divisor")
    `ASSERT_PROP(a_hold, clk, rst_n,
        valid_reg && !dn_ready |=> valid_reg && $stable(data_reg),
        "divider stage lost data while blocked")

endmodule

### src/piecewise_contrast_stretch.sv
// Channel  | Handshake           | Payload
// src      | src_valid/src_stall | pixel_in  [7:0]
// dst      | dst_valid/dst_stall | pixel_out [7:0]
// apb      | psel/penable/pready | paddr [3:0], pwdata/prdata [31:0]
//
// One pixel per cycle while dst is not stalled; stages: select, multiply, sum, 4 divider stages.
// Divider retires two quotient bits per stage.
// Reset loads the identity curve: in 0..255 -> out 0..255.
// Stalls back up stage by stage; empty stages still fill while dst is stalled.
`include "assert_macros.svh"

module piecewise_contrast_stretch (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcs_pkg::APB_AW-1:0]  paddr,
    input  logic [pcs_pkg::APB_DW-1:0]  pwdata,
    output logic [pcs_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        src_valid,
    output logic                        src_stall,
    input  logic [pcs_pkg::PIX_W-1:0]   pixel_in,
    output logic                        dst_valid,
    input  logic                        dst_stall,
    output logic [pcs_pkg::PIX_W-1:0]   pixel_out
);
    import pcs_pkg::*;

    logic [PIX_W-1:0] in_low_reg;
    logic [PIX_W-1:0] in_high_reg;
    logic [PIX_W-1:0] out_low_reg;
    logic [PIX_W-1:0] out_high_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_AW-1:APB_AW-REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_low_reg   <= '0;
            in_high_reg  <= PIX_MAX;
            out_low_reg  <= '0;
            out_high_reg <= PIX_MAX;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_IN_LOW:   in_low_reg   <= pwdata[PIX_W-1:0];
                REG_IN_HIGH:  in_high_reg  <= pwdata[PIX_W-1:0];
                REG_OUT_LOW:  out_low_reg  <= pwdata[PIX_W-1:0];
                REG_OUT_HIGH: out_high_reg <= pwdata[PIX_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_IN_LOW:   prdata = APB_DW'(in_low_reg);
            REG_IN_HIGH:  prdata = APB_DW'(in_high_reg);
            REG_OUT_LOW:  prdata = APB_DW'(out_low_reg);
            REG_OUT_HIGH: prdata = APB_DW'(out_high_reg);
            default:      prdata = '0;
        endcase
    end

    // stage 1: segment select, operands for N = a0*b0 + a1*b1 and divisor D
    logic             s1_valid_reg;
    logic             s1_ready;
    logic [PIX_W-1:0] a0_reg, b0_reg, a1_reg, b1_reg, d1_reg;
    logic [PIX_W-1:0] a0_next, b0_next, a1_next, b1_next, d1_next;

    always_comb
    begin
        if (pixel_in < in_low_reg)
        begin
            a0_next = pixel_in;
            b0_next = out_low_reg;
            a1_next = '0;
            b1_next = '0;
            d1_next = in_low_reg;
        end
        else if (pixel_in > in_high_reg)
        begin
            a0_next = out_high_reg;
            b0_next = PIX_MAX - in_high_reg;
            a1_next = pixel_in - in_high_reg;
            b1_next = PIX_MAX - out_high_reg;
            d1_next = PIX_MAX - in_high_reg;
        end
        else if (in_high_reg == in_low_reg)
        begin
            a0_next = out_low_reg;
            b0_next = PIX_W'(1);
            a1_next = '0;
            b1_next = '0;
            d1_next = PIX_W'(1);
        end
        else
        begin
            a0_next = out_low_reg;
            b0_next = in_high_reg - pixel_in;
            a1_next = out_high_reg;
            b1_next = pixel_in - in_low_reg;
            d1_next = in_high_reg - in_low_reg;
        end
    end

    // stage 2: products
    logic              s2_valid_reg;
    logic              s2_ready;
    logic [PROD_W-1:0] p0_reg, p1_reg;
    logic [PIX_W-1:0]  d2_reg;

    // stage 3: rounded dividend 2N + D, divisor 2D
    logic     s3_valid_reg;
    logic     s3_ready;
    pcs_div_t s3_data_reg;
    pcs_div_t s3_data_next;

    logic     div_valid [DIV_STAGES+1];
    logic     div_ready [DIV_STAGES+1];
    pcs_div_t div_data  [DIV_STAGES+1];

    assign s3_ready  = !s3_valid_reg || div_ready[0];
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign src_stall = !s1_ready;

    always_comb
    begin
        logic [PROD_W-1:0] sum;
        sum = p0_reg + p1_reg;
        s3_data_next.rem = {sum, 1'b0} + DIVD_W'(d2_reg);
        s3_data_next.dvs = {d2_reg, 1'b0};
        s3_data_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= src_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && s1_ready)
        begin
            a0_reg <= a0_next;
            b0_reg <= b0_next;
            a1_reg <= a1_next;
            b1_reg <= b1_next;
            d1_reg <= d1_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            p0_reg <= a0_reg * b0_reg;
            p1_reg <= a1_reg * b1_reg;
            d2_reg <= d1_reg;
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_data_reg <= s3_data_next;
        end
    end

    assign div_valid[0] = s3_valid_reg;
    assign div_data[0]  = s3_data_reg;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        pcs_div_stage #(
            .STAGE (k)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (div_valid[k]),
            .up_data  (div_data[k]),
            .up_ready (div_ready[k]),
            .dn_valid (div_valid[k+1]),
            .dn_data  (div_data[k+1]),
            .dn_ready (div_ready[k+1])
        );
    end

    assign div_ready[DIV_STAGES] = !dst_stall;
    assign dst_valid = div_valid[DIV_STAGES];
    assign pixel_out = div_data[DIV_STAGES].quo;

    `ASSERT_NEVER(a_s1_zero_div, clk, rst_n,
        s1_valid_reg && (d1_reg == '0),
        "zero divisor selected")
    `ASSERT_PROP(a_quo_fits, clk, rst_n,
        s3_valid_reg |-> (s3_data_reg.rem < (DIVD_W'(s3_data_reg.dvs) << PIX_W)),
        "quotient would exceed pixel range")
    `ASSERT_PROP(a_cfg_in_low, clk, rst_n,
        cfg_wr && (cfg_idx == REG_IN_LOW) |=> in_low_reg == $past(pwdata[PIX_W-1:0]),
        "in_low write not taken")

endmodule

### tb/piecewise_contrast_stretch_test.sv
`timescale 1ns / 100ps

module piecewise_contrast_stretch_test;
    import pcs_pkg::*;

    localparam int RANDOM_PIXELS = 600;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PIPE_CYCLES   = 7;

    typedef enum logic {
        ROW_PIXEL,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [REG_IDX_W-1:0]   reg_idx;
        logic [PIX_W-1:0]       level;
        logic                   known;
        logic [PIX_W-1:0]       want;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 src_valid;
    logic                 src_stall;
    logic [PIX_W-1:0]     pixel_in;
    logic                 dst_valid;
    logic                 dst_stall;
    logic [PIX_W-1:0]     pixel_out;

    logic [PIX_W-1:0]     curve_in_low;
    logic [PIX_W-1:0]     curve_in_high;
    logic [PIX_W-1:0]     curve_out_low;
    logic [PIX_W-1:0]     curve_out_high;

    logic [PIX_W-1:0]     expected_levels[$];
    bit                   mismatch_seen;
    bit                   streaming;
    bit                   src_burst;
    bit                   sink_burst;
    int                   quiet_cycles;

    script_row_t          directed_rows[39];

    piecewise_contrast_stretch DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .pixel_in  (pixel_in),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .pixel_out (pixel_out)
    );

    always #6 clk = ~clk;

    function automatic int rounded_quotient(input int num, input int den);
        if (den <= 0 || num < 0)
        begin
            return 0;
        end
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic logic [PIX_W-1:0] stretch_level(input logic [PIX_W-1:0] level);
        int x;
        int il;
        int ih;
        int ol;
        int oh;
        int top;
        int d;
        int r;
        x   = level;
        il  = curve_in_low;
        ih  = curve_in_high;
        ol  = curve_out_low;
        oh  = curve_out_high;
        top = PIX_MAX;
        if (x < il)
        begin
            r = rounded_quotient(x * ol, il);
        end
        else if (x > ih)
        begin
            d = top - ih;
            r = rounded_quotient(oh * d + (x - ih) * (top - oh), d);
        end
        else if (ih == il)
        begin
            r = ol;
        end
        else
        begin
            d = ih - il;
            r = rounded_quotient(ol * d + (oh - ol) * (x - il), d);
        end
        if (r < 0)
        begin
            r = 0;
        end
        if (r > top)
        begin
            r = top;
        end
        return r[PIX_W-1:0];
    endfunction

    function automatic script_row_t pix(input logic [PIX_W-1:0] level);
        return '{ROW_PIXEL, REG_IN_LOW, level, 1'b0, level};
    endfunction

    function automatic script_row_t pix_known(input logic [PIX_W-1:0] level,
                                              input logic [PIX_W-1:0] want);
        return '{ROW_PIXEL, REG_IN_LOW, level, 1'b1, want};
    endfunction

    function automatic script_row_t wr(input logic [REG_IDX_W-1:0] idx,
                                       input logic [PIX_W-1:0] value);
        return '{ROW_WRITE, idx, value, 1'b0, value};
    endfunction

    function automatic logic [PIX_W-1:0] pick_setting();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return PIX_MAX;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_level();
        int v;
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = PIX_MAX;
            2: v = int'(curve_in_low) + int'($urandom_range(0, 4)) - 2;
            3: v = int'(curve_in_high) + int'($urandom_range(0, 4)) - 2;
            default: v = $urandom_range(0, 255);
        endcase
        if (v < 0)
        begin
            v = 0;
        end
        if (v > PIX_MAX)
        begin
            v = PIX_MAX;
        end
        return v[PIX_W-1:0];
    endfunction

    // back-to-back writes keep psel high; the bus is released before streaming
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PIX_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        case (idx)
            REG_IN_LOW:   curve_in_low   = value;
            REG_IN_HIGH:  curve_in_high  = value;
            REG_OUT_LOW:  curve_out_low  = value;
            REG_OUT_HIGH: curve_out_high = value;
            default:      ;
        endcase
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] level, input logic known,
                              input logic [PIX_W-1:0] want);
        int gap;
        if (psel)
        begin
            psel    <= 1'b0;
            penable <= 1'b0;
        end
        gap = src_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        pixel_in  <= level;
        streaming = 1'b1;
        do
            @(posedge clk);
        while (src_stall !== 1'b0);
        expected_levels.push_back(known ? want : stretch_level(level));
    endtask

    task automatic drain_pipe();
        if (streaming)
        begin
            src_valid <= 1'b0;
            while (expected_levels.size() != 0)
                @(posedge clk);
            repeat (PIPE_CYCLES + 2) @(posedge clk);
            streaming = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && dst_valid === 1'b1 && dst_stall === 1'b0)
        begin
            if (expected_levels.size() == 0)
            begin
                $error("pixel_out: expected nothing, actual %0d", pixel_out);
                mismatch_seen = 1'b1;
            end
            else if (pixel_out !== expected_levels[0])
            begin
                $error("pixel_out: expected %0d, actual %0d", expected_levels[0], pixel_out);
                mismatch_seen = 1'b1;
                void'(expected_levels.pop_front());
            end
            else
            begin
                void'(expected_levels.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((src_valid && src_stall === 1'b0) || (dst_valid === 1'b1 && !dst_stall)
            || (psel && penable))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("piecewise_contrast_stretch: mismatch");
            $finish;
        end
    end

    initial
    begin
        int hold;
        dst_stall <= 1'b1;
        @(posedge clk);
        forever
        begin
            hold = sink_burst ? 0 : $urandom_range(0, 14);
            if (hold > 0)
            begin
                dst_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            dst_stall <= 1'b0;
            do
                @(posedge clk);
            while (dst_valid !== 1'b1);
        end
    end

    initial
    begin
        int sent;
        int n;
        logic [PIX_W-1:0] il;
        logic [PIX_W-1:0] ih;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        src_valid <= 1'b0;
        pixel_in  <= '0;
        curve_in_low   = '0;
        curve_in_high  = PIX_MAX;
        curve_out_low  = '0;
        curve_out_high = PIX_MAX;
        mismatch_seen  = 1'b0;
        streaming      = 1'b0;
        src_burst      = 1'b0;
        sink_burst     = 1'b0;
        quiet_cycles   = 0;

        directed_rows = '{
            // identity curve after reset
            pix_known(8'd0, 8'd0), pix_known(8'd255, 8'd255), pix_known(8'd128, 8'd128),
            pix_known(8'd85, 8'd85), pix_known(8'd170, 8'd170),
            // all three segments
            wr(REG_IN_LOW, 8'd64), wr(REG_IN_HIGH, 8'd192),
            wr(REG_OUT_LOW, 8'd16), wr(REG_OUT_HIGH, 8'd240),
            pix_known(8'd0, 8'd0), pix(8'd63), pix_known(8'd64, 8'd16),
            pix_known(8'd192, 8'd240), pix(8'd193), pix_known(8'd255, 8'd255),
            // equal breakpoints
            wr(REG_IN_LOW, 8'd100), wr(REG_IN_HIGH, 8'd100),
            wr(REG_OUT_LOW, 8'd50), wr(REG_OUT_HIGH, 8'd200),
            pix_known(8'd100, 8'd50), pix(8'd99), pix(8'd101),
            // crossed breakpoints
            wr(REG_IN_LOW, 8'd200), wr(REG_IN_HIGH, 8'd50),
            pix(8'd100), pix(8'd199), pix(8'd200), pix(8'd10),
            // out_high below out_low, breakpoints at the top
            wr(REG_IN_LOW, 8'd255), wr(REG_IN_HIGH, 8'd255),
            wr(REG_OUT_LOW, 8'd255), wr(REG_OUT_HIGH, 8'd0),
            pix(8'd254), pix_known(8'd255, 8'd255),
            // breakpoints at zero
            wr(REG_IN_LOW, 8'd0), wr(REG_IN_HIGH, 8'd0), wr(REG_OUT_LOW, 8'd0),
            pix_known(8'd0, 8'd0), pix_known(8'd255, 8'd255)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                drain_pipe();
                apb_write(directed_rows[i].reg_idx, directed_rows[i].level);
            end
            else
            begin
                send_pixel(directed_rows[i].level, directed_rows[i].known,
                           directed_rows[i].want);
            end
        end

        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            drain_pipe();
            il = pick_setting();
            ih = ($urandom_range(0, 4) == 0) ? il : pick_setting();
            apb_write(REG_IN_LOW, il);
            apb_write(REG_IN_HIGH, ih);
            apb_write(REG_OUT_LOW, pick_setting());
            apb_write(REG_OUT_HIGH, pick_setting());
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            n = $urandom_range(30, 70);
            repeat (n) send_pixel(pick_level(), 1'b0, '0);
            sent = sent + n;
        end
        drain_pipe();
        if (psel)
        begin
            psel    <= 1'b0;
            penable <= 1'b0;
        end
        repeat (PIPE_CYCLES + 4) @(posedge clk);

        if (!mismatch_seen && expected_levels.size() == 0)
        begin
            $display("piecewise_contrast_stretch: match");
        end
        else
        begin
            $display("piecewise_contrast_stretch: mismatch");
        end
        $finish;
    end

endmodule
